>>> sv/ercu_pkg.sv
package ercu_pkg;

    localparam int FLOORS_DEF = 16;
    localparam int FLOOR_W    = 5;
    localparam int QDEPTH     = 5;
    localparam int QCNT_W     = 3;

    typedef enum logic [1:0] {
        MODE_PRESS,
        MODE_REACHED,
        MODE_APPEARS,
        MODE_STOPPED
    } t_mode;

    // DIR_CABIN only arrives with a button press; the car never moves that way
    typedef enum logic [1:0] {
        DIR_STOP,
        DIR_UP,
        DIR_DOWN,
        DIR_CABIN
    } t_dir;

    typedef enum logic [1:0] {
        BTN_UP,
        BTN_DOWN,
        BTN_CABIN
    } t_btn;

    typedef enum logic [1:0] {
        KIND_NEW,
        KIND_UNPRESS,
        KIND_STAY,
        KIND_OUT
    } t_kind;

    typedef enum logic [1:0] {
        CAR_OUT,
        CAR_FIND,
        CAR_TGT,
        CAR_APPEAR
    } t_car;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_SCAN_P,
        SEQ_REACH_P,
        SEQ_SCAN_A,
        SEQ_EMIT
    } t_seq;

    typedef struct packed {
        logic load_event;
        logic press;
        logic reach_ev;
        logic reach_cur;
        logic appear;
        logic scan;
        logic scan_new;
        logic stop;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  floor_ok;
        logic  car_tgt;
        logic  car_out;
        logic  q_empty;
        logic  out_free;
    } t_dp_stat;

endpackage

>>> sv/ercu_ctrl.sv
module ercu_ctrl
    import ercu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_ev_valid,
    output logic     o_ev_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_seq r_seq;
    t_seq n_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (i_ev_valid) n_seq = SEQ_DECODE;
            end
            SEQ_DECODE: begin
                case (i_stat.mode)
                    MODE_PRESS:   n_seq = i_stat.floor_ok ? SEQ_SCAN_P : SEQ_IDLE;
                    MODE_REACHED: n_seq = (i_stat.floor_ok && !i_stat.car_out) ?
                                          SEQ_EMIT : SEQ_IDLE;
                    MODE_APPEARS: n_seq = (i_stat.floor_ok && i_stat.car_tgt) ?
                                          SEQ_SCAN_A : SEQ_IDLE;
                    MODE_STOPPED: n_seq = i_stat.car_tgt ? SEQ_EMIT : SEQ_IDLE;
                    default:      n_seq = SEQ_IDLE;
                endcase
            end
            SEQ_SCAN_P:  n_seq = SEQ_REACH_P;
            SEQ_REACH_P: n_seq = SEQ_EMIT;
            SEQ_SCAN_A:  n_seq = SEQ_EMIT;
            SEQ_EMIT: begin
                if (i_stat.q_empty) n_seq = SEQ_IDLE;
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_ev_ready = 1'b0;
        case (r_seq)
            SEQ_IDLE: begin
                o_ev_ready       = 1'b1;
                o_cmd.load_event = i_ev_valid;
            end
            SEQ_DECODE: begin
                o_cmd.press    = (i_stat.mode == MODE_PRESS) && i_stat.floor_ok;
                o_cmd.reach_ev = (i_stat.mode == MODE_REACHED) && i_stat.floor_ok &&
                                 !i_stat.car_out;
                o_cmd.appear   = (i_stat.mode == MODE_APPEARS) && i_stat.floor_ok &&
                                 i_stat.car_tgt;
                o_cmd.stop     = (i_stat.mode == MODE_STOPPED) && i_stat.car_tgt;
            end
            SEQ_SCAN_P: begin
                o_cmd.scan = 1'b1;
            end
            SEQ_REACH_P: begin
                o_cmd.reach_cur = 1'b1;
            end
            SEQ_SCAN_A: begin
                o_cmd.scan     = 1'b1;
                o_cmd.scan_new = 1'b1;
            end
            SEQ_EMIT: begin
                o_cmd.pop = !i_stat.q_empty && i_stat.out_free;
            end
            default: begin
                o_ev_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/ercu_dp.sv
module ercu_dp
    import ercu_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [1:0]         i_ev_mode,
    input  logic [FLOOR_W-1:0] i_ev_floor,
    input  logic [1:0]         i_ev_dir,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output logic [1:0]         o_res_kind,
    output logic [FLOOR_W-1:0] o_res_at,
    output logic [FLOOR_W-1:0] o_res_goal,
    output logic [1:0]         o_res_button,
    output logic               o_res_last
);

    localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    // latched event
    t_mode              r_ev_mode;
    logic [FLOOR_W-1:0] r_ev_floor;
    t_dir               r_ev_dir;

    // car state
    t_car               r_car,  n_car;
    logic [FLOOR_W-1:0] r_cur,  n_cur;
    logic [FLOOR_W-1:0] r_tgt,  n_tgt;
    t_dir               r_dir,  n_dir;
    logic [FLOORS-1:0]  r_up,   n_up;
    logic [FLOORS-1:0]  r_down, n_down;
    logic [FLOORS-1:0]  r_cab,  n_cab;

    // result queue and output register
    t_kind              r_q_kind [QDEPTH];
    t_btn               r_q_btn  [QDEPTH];
    t_kind              n_q_kind [QDEPTH];
    t_btn               n_q_btn  [QDEPTH];
    logic [QCNT_W-1:0]  r_q_cnt, n_q_cnt;

    logic               r_out_valid;
    t_kind              r_out_kind;
    t_btn               r_out_btn;
    logic [FLOOR_W-1:0] r_out_at;
    logic [FLOOR_W-1:0] r_out_goal;
    logic               r_out_last;

    t_dir               ev_dir_mv;
    logic               floor_ok;
    logic [FLOOR_W-1:0] rf;
    t_dir               rd;
    logic [FLOORS-1:0]  fb;
    logic [FLOORS-1:0]  req;
    logic [FLOORS-1:0]  le_mask;
    logic [FLOORS-1:0]  ge_mask;
    logic [IDX_W-1:0]   lo_idx;
    logic [IDX_W-1:0]   hi_idx;
    logic               found;
    t_dir               scan_dir;
    logic [FLOOR_W-1:0] scan_tgt;
    logic               hit_down;
    logic               hit_up;
    logic               hit_cab;
    logic               hit_tgt;
    logic [QCNT_W-1:0]  base;

    assign ev_dir_mv = (r_ev_dir == DIR_CABIN) ? DIR_STOP : r_ev_dir;
    assign floor_ok  = (r_ev_floor != '0) && (32'(r_ev_floor) <= 32'(FLOORS));

    // reach handling at the current floor after a press, else at the event floor
    assign rf = i_cmd.reach_cur ? r_cur : r_ev_floor;
    assign rd = i_cmd.reach_cur ? r_dir : ev_dir_mv;

    assign req = r_up | r_down | r_cab;

    always_comb begin
        for (int i = 0; i < FLOORS; i++) begin
            fb[i]      = (32'(rf) == 32'(i + 1));
            le_mask[i] = (32'(i) < 32'(r_cur));
            ge_mask[i] = (32'(i + 1) >= 32'(r_cur));
        end
    end

    always_comb begin
        lo_idx = '0;
        hi_idx = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (req[i]) lo_idx = IDX_W'(i);
        end
        for (int i = 0; i < FLOORS; i++) begin
            if (req[i]) hi_idx = IDX_W'(i);
        end
    end

    // the lowest request lies at or below the car whenever any does, and the
    // highest lies at or above it whenever any does
    always_comb begin
        found    = |req;
        scan_dir = r_dir;
        scan_tgt = r_tgt;
        if (r_dir == DIR_UP) begin
            if (|(req & ge_mask)) begin
                scan_dir = DIR_UP;
                scan_tgt = FLOOR_W'(32'(hi_idx) + 1);
            end else if (found) begin
                scan_dir = DIR_DOWN;
                scan_tgt = FLOOR_W'(32'(lo_idx) + 1);
            end
        end else begin
            if (|(req & le_mask)) begin
                scan_dir = DIR_DOWN;
                scan_tgt = FLOOR_W'(32'(lo_idx) + 1);
            end else if (found) begin
                scan_dir = DIR_UP;
                scan_tgt = FLOOR_W'(32'(hi_idx) + 1);
            end
        end
    end

    assign hit_down = (rd == DIR_DOWN) && |(r_down & fb);
    assign hit_up   = (rd == DIR_UP) && |(r_up & fb);
    assign hit_cab  = |(r_cab & fb);
    assign hit_tgt  = (rf == r_tgt);
    assign base     = i_cmd.reach_cur ? QCNT_W'(1) : QCNT_W'(0);

    always_comb begin
        n_car    = r_car;
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_dir    = r_dir;
        n_up     = r_up;
        n_down   = r_down;
        n_cab    = r_cab;
        n_q_cnt  = r_q_cnt;
        n_q_kind = r_q_kind;
        n_q_btn  = r_q_btn;

        if (i_cmd.press) begin
            case (r_ev_dir)
                DIR_UP:    n_up   = r_up | fb;
                DIR_DOWN:  n_down = r_down | fb;
                DIR_CABIN: n_cab  = r_cab | fb;
                default:   n_cab  = r_cab;
            endcase
            n_car = CAR_FIND;
        end

        if (i_cmd.scan && found) begin
            n_dir = scan_dir;
            n_tgt = scan_tgt;
        end
        if (i_cmd.scan_new) begin
            n_q_kind[0] = KIND_NEW;
            n_q_btn[0]  = BTN_UP;
            n_q_cnt     = found ? QCNT_W'(1) : QCNT_W'(0);
        end

        if (i_cmd.appear) begin
            n_car = CAR_APPEAR;
            n_cur = r_ev_floor;
            n_dir = ev_dir_mv;
        end

        if (i_cmd.stop) begin
            n_car       = CAR_OUT;
            n_dir       = DIR_STOP;
            n_tgt       = r_cur;
            n_q_kind[0] = KIND_OUT;
            n_q_btn[0]  = BTN_UP;
            n_q_cnt     = QCNT_W'(1);
        end

        if (i_cmd.reach_ev || i_cmd.reach_cur) begin
            n_car = CAR_TGT;
            n_cur = rf;
            n_dir = rd;
            if (i_cmd.reach_cur) begin
                n_q_kind[0] = KIND_NEW;
                n_q_btn[0]  = BTN_UP;
            end
            n_q_cnt = base;
            if (hit_down) begin
                n_cab  = r_cab & ~fb;
                n_down = r_down & ~fb;
                n_q_kind[base]              = KIND_UNPRESS;
                n_q_btn[base]               = BTN_CABIN;
                n_q_kind[base + QCNT_W'(1)] = KIND_UNPRESS;
                n_q_btn[base + QCNT_W'(1)]  = BTN_DOWN;
                n_q_kind[base + QCNT_W'(2)] = KIND_STAY;
                n_q_btn[base + QCNT_W'(2)]  = BTN_UP;
                n_q_cnt                     = base + QCNT_W'(3);
            end else if (hit_up) begin
                n_cab = r_cab & ~fb;
                n_up  = r_up & ~fb;
                n_q_kind[base]              = KIND_UNPRESS;
                n_q_btn[base]               = BTN_CABIN;
                n_q_kind[base + QCNT_W'(1)] = KIND_UNPRESS;
                n_q_btn[base + QCNT_W'(1)]  = BTN_UP;
                n_q_kind[base + QCNT_W'(2)] = KIND_STAY;
                n_q_btn[base + QCNT_W'(2)]  = BTN_UP;
                n_q_cnt                     = base + QCNT_W'(3);
            end else if (hit_cab) begin
                n_cab = r_cab & ~fb;
                n_q_kind[base]              = KIND_UNPRESS;
                n_q_btn[base]               = BTN_CABIN;
                n_q_kind[base + QCNT_W'(1)] = KIND_STAY;
                n_q_btn[base + QCNT_W'(1)]  = BTN_UP;
                n_q_cnt                     = base + QCNT_W'(2);
            end else if (hit_tgt) begin
                n_cab  = r_cab & ~fb;
                n_down = r_down & ~fb;
                n_up   = r_up & ~fb;
                n_q_kind[base]              = KIND_UNPRESS;
                n_q_btn[base]               = BTN_CABIN;
                n_q_kind[base + QCNT_W'(1)] = KIND_UNPRESS;
                n_q_btn[base + QCNT_W'(1)]  = BTN_DOWN;
                n_q_kind[base + QCNT_W'(2)] = KIND_UNPRESS;
                n_q_btn[base + QCNT_W'(2)]  = BTN_UP;
                n_q_kind[base + QCNT_W'(3)] = KIND_STAY;
                n_q_btn[base + QCNT_W'(3)]  = BTN_UP;
                n_q_cnt                     = base + QCNT_W'(4);
            end
        end

        // advance the queue by one beat
        if (i_cmd.pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                n_q_kind[i] = r_q_kind[i + 1];
                n_q_btn[i]  = r_q_btn[i + 1];
            end
            n_q_cnt = r_q_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_event) begin
            r_ev_mode  <= t_mode'(i_ev_mode);
            r_ev_floor <= i_ev_floor;
            r_ev_dir   <= t_dir'(i_ev_dir);
        end
        r_q_kind <= n_q_kind;
        r_q_btn  <= n_q_btn;
        if (i_cmd.pop) begin
            r_out_kind <= r_q_kind[0];
            r_out_btn  <= r_q_btn[0];
            r_out_at   <= r_cur;
            r_out_goal <= r_tgt;
            r_out_last <= (r_q_cnt == QCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car       <= CAR_OUT;
            r_cur       <= FLOOR_W'(1);
            r_tgt       <= FLOOR_W'(1);
            r_dir       <= DIR_STOP;
            r_up        <= '0;
            r_down      <= '0;
            r_cab       <= '0;
            r_q_cnt     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_car   <= n_car;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_dir   <= n_dir;
            r_up    <= n_up;
            r_down  <= n_down;
            r_cab   <= n_cab;
            r_q_cnt <= n_q_cnt;
            if (i_cmd.pop) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.mode     = r_ev_mode;
    assign o_stat.floor_ok = floor_ok;
    assign o_stat.car_tgt  = (r_car == CAR_TGT);
    assign o_stat.car_out  = (r_car == CAR_OUT);
    assign o_stat.q_empty  = (r_q_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_res_ready;

    assign o_res_valid  = r_out_valid;
    assign o_res_kind   = r_out_kind;
    assign o_res_at     = r_out_at;
    assign o_res_goal   = r_out_goal;
    assign o_res_button = r_out_btn;
    assign o_res_last   = r_out_last;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_q_cnt) <= 32'(QDEPTH))
        else $error("result queue overfilled");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_q_cnt != '0) && (!r_out_valid || i_res_ready))
        else $error("pop without a result or without room");

    a_dir_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir != DIR_CABIN)
        else $error("car direction holds a button code");

    a_floors_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != '0) && (r_tgt != '0))
        else $error("car or target floor is zero");
`endif

endmodule

>>> sv/elevator_request_controller_unit.sv
// Sequence: an accepted event is latched and decoded; a floor reached or stopped event
// then emits its results, a floor appearing rescans first, a button press scans, then reaches.
// Throughput: one event at a time, results one beat per cycle (up to five) unless the output
// stalls; the next event is accepted only once every result has left the queue, and an
// ignored event goes straight back to idle; each stalled result beat holds the sequence.
// Reset (synchronous, active low): car out of target at floor 1, no requests.
module elevator_request_controller_unit
    import ercu_pkg::*;
#(
    parameter int FLOORS = FLOORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] floor, [6:5] direction, [7] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] at_floor, [9:5] goal_floor,
                                        // [11:10] button, [15:12] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [FLOOR_W-1:0] res_at;
    logic [FLOOR_W-1:0] res_goal;
    logic [1:0]         res_button;

    ercu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (s_axis_tvalid),
        .o_ev_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ercu_dp #(
        .FLOORS (FLOORS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_ev_mode    (s_axis_tuser),
        .i_ev_floor   (s_axis_tdata[4:0]),
        .i_ev_dir     (s_axis_tdata[6:5]),
        .i_res_ready  (m_axis_tready),
        .o_res_valid  (m_axis_tvalid),
        .o_res_kind   (m_axis_tuser),
        .o_res_at     (res_at),
        .o_res_goal   (res_goal),
        .o_res_button (res_button),
        .o_res_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, res_button, res_goal, res_at};

endmodule
